FILE: src/ust_pkg.sv
package ust_pkg;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_EDIT   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_QUERY  = 3'd4
  } ust_op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } ust_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } ust_state_e;

  typedef struct packed {
    ust_status_e status;
    logic        found;
  } ust_result_t;

endpackage

FILE: src/ust_ram.sv
module ust_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/ust_seq.sv
module ust_seq
  import ust_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [2:0]             op_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [VALUE_WIDTH-1:0] new_value_i,
  output logic                   busy_o,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output ust_result_t            result_o,
  output logic [CW-1:0]          count_o
);

  ust_state_e             state_q, state_d;
  logic [2:0]             op_q, op_d;
  logic [VALUE_WIDTH-1:0] key_q, key_d;
  logic [VALUE_WIDTH-1:0] new_key_q, new_key_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [AW-1:0]          pos_q, pos_d;
  logic                   second_q, second_d;
  ust_result_t            result_q, result_d;
  logic [CW-1:0]          count_q, count_d;

  logic                   we;
  logic [AW-1:0]          waddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [VALUE_WIDTH-1:0] rdata;
  logic [CW-1:0]          idx_prev;
  logic                   match;

  ust_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(rdata)
  );

  // single comparator, shared by the old-value and new-value scans
  assign match    = (rdata == (second_q ? new_key_q : key_q));
  assign idx_prev = idx_q - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    new_key_q <= new_key_d;
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    second_q  <= second_d;
    result_q  <= result_d;
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    key_d     = key_q;
    new_key_d = new_key_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    second_d  = second_q;
    result_d  = result_q;
    count_d   = count_q;
    we        = 1'b0;
    waddr     = pos_q;
    wdata     = key_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d            = op_i;
          key_d           = value_i;
          new_key_d       = new_value_i;
          idx_d           = '0;
          second_d        = 1'b0;
          result_d.status = ST_OK;
          result_d.found  = 1'b0;
          priority if (op_i == OP_CLEAR) begin
            count_d = '0;
            state_d = S_DONE;
          end else if ((op_i == OP_DELETE || op_i == OP_EDIT) && count_q == '0) begin
            result_d.status = ST_EMPTY;
            state_d         = S_DONE;
          end else if (op_i == OP_INSERT || op_i == OP_DELETE || op_i == OP_EDIT ||
                       op_i == OP_QUERY) begin
            state_d = S_RD;
          end else begin
            // unused codes: answer ok and leave the set alone
            state_d = S_DONE;
          end
        end
      end

      S_RD: begin
        if (idx_q == count_q) begin
          // scan ran off the end: key absent
          state_d = S_DONE;
          if (second_q) begin
            we    = 1'b1;
            waddr = pos_q;
            wdata = new_key_q;
          end else begin
            unique case (op_q)
              OP_INSERT: begin
                if (count_q == CW'(CAPACITY)) begin
                  result_d.status = ST_FULL;
                end else begin
                  we      = 1'b1;
                  waddr   = count_q[AW-1:0];
                  wdata   = key_q;
                  count_d = count_q + 1'b1;
                end
              end
              OP_DELETE, OP_EDIT: result_d.status = ST_NOTFOUND;
              default: ;
            endcase
          end
        end else begin
          state_d = S_CMP;
        end
      end

      S_CMP: begin
        if (match) begin
          if (second_q) begin
            result_d.status = ST_DUP;
            state_d         = S_DONE;
          end else begin
            result_d.found = 1'b1;
            unique case (op_q)
              OP_INSERT: begin
                result_d.status = ST_DUP;
                state_d         = S_DONE;
              end
              OP_DELETE: begin
                pos_d   = idx_q[AW-1:0];
                idx_d   = idx_q + 1'b1;
                state_d = S_SHIFT_RD;
              end
              OP_EDIT: begin
                // now look for the new value across the whole set
                pos_d    = idx_q[AW-1:0];
                idx_d    = '0;
                second_d = 1'b1;
                state_d  = S_RD;
              end
              default: state_d = S_DONE;
            endcase
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_RD;
        end
      end

      S_SHIFT_RD: begin
        if (idx_q == count_q) begin
          count_d = count_q - 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        // move entry down one slot to close the gap
        we      = 1'b1;
        waddr   = idx_prev[AW-1:0];
        wdata   = rdata;
        idx_d   = idx_q + 1'b1;
        state_d = S_SHIFT_RD;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign result_o    = result_q;
  assign count_o     = count_q;

endmodule

FILE: src/unique_set_table.sv
// Duplicate-free set of up to CAPACITY values kept in insertion order.
// Input channel (in_valid_i / in_stall_o) carries one transaction: operation
// (insert, delete, edit, clear, query), value and new_value. Output channel
// (out_valid_o / out_stall_i) returns one transaction per input: status,
// found and the element count after the operation.
// A transaction moves on a rising edge with valid high and stall low.
// Entries sit in a one-read-port RAM and are scanned one at a time through
// a single comparator. Clear, unused codes and delete/edit on an empty set
// skip the scan; edit scans a second time, for the new value, once the old
// value is found; delete also moves each later entry down one slot.
// in_stall_o is high while an operation is in flight. The result lands in
// an output register; a new transaction may be accepted while it waits.
// If the receiver stalls, the result holds and a finished operation waits
// for the register to free up.
// Reset empties the set (count 0) and needs no clearing pass; entry
// contents are not reset.
module unique_set_table
  import ust_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [2:0]             operation_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [VALUE_WIDTH-1:0] new_value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             status_o,
  output logic                   found_o,
  output logic [CW-1:0]          count_o
);

  logic          busy;
  logic          res_valid;
  logic          load;
  ust_result_t   result;
  logic [CW-1:0] count;

  logic          out_valid_q;
  ust_result_t   out_result_q;
  logic [CW-1:0] out_count_q;

  ust_seq #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_valid_i && !busy),
    .op_i       (operation_i),
    .value_i    (value_i),
    .new_value_i(new_value_i),
    .busy_o     (busy),
    .res_valid_o(res_valid),
    .res_ready_i(load),
    .result_o   (result),
    .count_o    (count)
  );

  assign load = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_result_q <= result;
      out_count_q  <= count;
    end
  end

  assign in_stall_o  = busy;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_result_q.status;
  assign found_o     = out_result_q.found;
  assign count_o     = out_count_q;

endmodule

FILE: src/ust_checker.sv
module ust_checker
  import ust_pkg::*;
#(
  parameter int CAPACITY    = 16,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [2:0]             status_o,
  input logic                   found_o,
  input logic [CW-1:0]          count_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(status_o) && $stable(found_o) && $stable(count_o))
    else $error("stalled result changed");

  // an accepted transaction always makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted on back-to-back cycles");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_o <= CW'(CAPACITY))
    else $error("count above capacity");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> count_o == CW'(CAPACITY) && !found_o)
    else $error("set-full status with room left");

  a_miss_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY || status_o == ST_NOTFOUND) |->
      !found_o && (status_o != ST_EMPTY || count_o == '0))
    else $error("miss status inconsistent with found or count");

endmodule

bind unique_set_table ust_checker #(
  .CAPACITY   (CAPACITY)
) u_ust_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .status_o   (status_o),
  .found_o    (found_o),
  .count_o    (count_o)
);

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ust_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int CW          = $clog2(CAPACITY + 1);
  localparam int RANDOM_CMDS = 1400;
  localparam int POOL_SIZE   = 24;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [2:0]             op;
    logic [VALUE_WIDTH-1:0] value;
    logic [VALUE_WIDTH-1:0] new_value;
  } set_cmd_t;

  typedef struct {
    logic [2:0]    status;
    logic          found;
    logic [CW-1:0] count;
  } set_reply_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid = 1'b0;
  logic [2:0]             op_drv = '0;
  logic [VALUE_WIDTH-1:0] value_drv = '0;
  logic [VALUE_WIDTH-1:0] new_value_drv = '0;
  logic                   out_stall = 1'b0;
  logic                   in_stall_o;
  logic                   out_valid_o;
  logic [2:0]             status_o;
  logic                   found_o;
  logic [CW-1:0]          count_o;

  set_cmd_t               pending_cmds[$];
  set_reply_t             expected_replies[$];
  logic [VALUE_WIDTH-1:0] held_vals[CAPACITY];
  int unsigned            held_count = 0;
  logic [VALUE_WIDTH-1:0] value_pool[POOL_SIZE];
  int unsigned            total_cmds = 1;
  int unsigned            accepted_cmds = 0;
  int unsigned            replies_seen = 0;
  int unsigned            errors = 0;
  int unsigned            cycles = 0;

  unique_set_table #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .operation_i(op_drv),
    .value_i    (value_drv),
    .new_value_i(new_value_drv),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .status_o   (status_o),
    .found_o    (found_o),
    .count_o    (count_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Phases: none, sender idle, receiver stalls, both.
  function automatic int unsigned send_idle_pct();
    int unsigned ph;
    ph = accepted_cmds * 4 / total_cmds;
    if (ph == 1) return 74;
    if (ph == 3) return 28;
    return 0;
  endfunction

  function automatic int unsigned recv_stall_pct();
    int unsigned ph;
    ph = replies_seen * 4 / total_cmds;
    if (ph == 2) return 74;
    if (ph == 3) return 28;
    return 0;
  endfunction

  function automatic int find_entry(logic [VALUE_WIDTH-1:0] v);
    for (int i = 0; i < held_count; i++) begin
      if (held_vals[i] == v) return i;
    end
    return -1;
  endfunction

  // Apply one transaction to the shadow set and return the expected reply.
  function automatic set_reply_t apply_set_op(set_cmd_t cmd);
    set_reply_t r;
    int pos;
    r.status = ST_OK;
    r.found  = 1'b0;
    pos = find_entry(cmd.value);
    case (cmd.op)
      OP_INSERT: begin
        if (pos >= 0) begin
          r.status = ST_DUP;
          r.found  = 1'b1;
        end else if (held_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          held_vals[held_count] = cmd.value;
          held_count++;
        end
      end
      OP_DELETE: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else if (pos < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.found = 1'b1;
          // close the gap, keep order
          for (int i = pos; i + 1 < held_count; i++) held_vals[i] = held_vals[i+1];
          held_count--;
        end
      end
      OP_EDIT: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else if (pos < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.found = 1'b1;
          if (find_entry(cmd.new_value) >= 0) r.status = ST_DUP;
          else held_vals[pos] = cmd.new_value;
        end
      end
      OP_CLEAR: held_count = 0;
      OP_QUERY: r.found = (pos >= 0);
      default: ;
    endcase
    r.count = held_count[CW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch on %s in result %0d: got %0d, want %0d", what, replies_seen, got,
             want);
    errors++;
  endtask

  task automatic add_cmd(logic [2:0] op, logic [VALUE_WIDTH-1:0] v,
                         logic [VALUE_WIDTH-1:0] nv);
    set_cmd_t c;
    c.op        = op;
    c.value     = v;
    c.new_value = nv;
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    if ($urandom_range(0, 99) < 90) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_op();
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 30) return OP_INSERT;
    if (w < 50) return OP_DELETE;
    if (w < 70) return OP_EDIT;
    if (w < 95) return OP_QUERY;
    if (w < 97) return OP_CLEAR;
    return 3'($urandom_range(5, 7));
  endfunction

  // Driver: present pending transactions, hold payload while stalled.
  always @(posedge clk_i) begin
    logic take;
    set_cmd_t c;
    if (rst_ni) begin
      take = !in_valid;
      if (in_valid && !in_stall_o) begin
        c.op        = op_drv;
        c.value     = value_drv;
        c.new_value = new_value_drv;
        expected_replies.insert(expected_replies.size(), apply_set_op(c));
        accepted_cmds++;
        take = 1'b1;
      end
      if (take) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          c = pending_cmds.pop_front();
          op_drv        <= c.op;
          value_drv     <= c.value;
          new_value_drv <= c.new_value;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction against the oldest expectation.
  always @(posedge clk_i) begin
    set_reply_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (expected_replies.size() == 0) begin
          $display("unexpected result: status %0d found %0d count %0d", status_o, found_o,
                   count_o);
          errors++;
        end else begin
          want = expected_replies.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", 32'(status_o), 32'(want.status));
          if (found_o !== want.found)
            report_mismatch("found", 32'(found_o), 32'(want.found));
          if (count_o !== want.count)
            report_mismatch("count", 32'(count_o), 32'(want.count));
        end
        replies_seen++;
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct());
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int unsigned made;
    int unsigned n;
    logic [VALUE_WIDTH-1:0] a;
    logic [VALUE_WIDTH-1:0] b;
    logic [2:0]             op_pick;
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    a = 32'h5a5a_a5a5;
    b = 32'h8000_0001;

    // directed: empty-set cases, extremes, duplicates, unused codes, clear
    add_cmd(OP_QUERY, '0, '0);
    add_cmd(OP_DELETE, '1, '0);
    add_cmd(OP_EDIT, '0, '1);
    add_cmd(OP_INSERT, '0, '1);
    add_cmd(OP_INSERT, '1, '0);
    add_cmd(OP_INSERT, '0, '0);
    add_cmd(OP_QUERY, '0, '1);
    add_cmd(OP_QUERY, a, '0);
    add_cmd(OP_EDIT, '0, '0);
    add_cmd(OP_EDIT, '1, '0);
    add_cmd(OP_EDIT, a, b);
    add_cmd(OP_EDIT, '0, a);
    add_cmd(OP_INSERT, b, '1);
    add_cmd(OP_DELETE, b ^ 1, '0);
    add_cmd(OP_DELETE, a, '0);
    add_cmd(OP_QUERY, '1, '0);
    add_cmd(3'd5, '1, '1);
    add_cmd(3'd6, a, b);
    add_cmd(3'd7, '0, '1);
    add_cmd(OP_DELETE, b, '0);
    add_cmd(OP_CLEAR, '1, '1);
    add_cmd(OP_QUERY, '0, '0);
    add_cmd(OP_INSERT, a, '0);
    add_cmd(OP_DELETE, a, '0);

    // random bursts: fill, mixed traffic, drain, noise, clear
    made = 0;
    while (made < RANDOM_CMDS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          n = $urandom_range(4, 20);
          for (int i = 0; i < n; i++) add_cmd(OP_INSERT, pick_value(), $urandom);
          made += n;
        end
        7: begin
          n = $urandom_range(3, 12);
          for (int i = 0; i < n; i++) add_cmd(OP_DELETE, pick_value(), $urandom);
          made += n;
        end
        8: begin
          n = $urandom_range(2, 6);
          for (int i = 0; i < n; i++) begin
            op_pick = 3'($urandom);
            add_cmd(op_pick, $urandom, $urandom);
            if (op_pick <= OP_QUERY) made++;
          end
        end
        9: begin
          add_cmd(OP_CLEAR, $urandom, $urandom);
          made++;
        end
        default: begin
          n = $urandom_range(4, 16);
          for (int i = 0; i < n; i++) begin
            op_pick = pick_op();
            add_cmd(op_pick, pick_value(), pick_value());
            if (op_pick <= OP_QUERY) made++;
          end
        end
      endcase
    end
    total_cmds = pending_cmds.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() > 0 || in_valid || expected_replies.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_replies.size() > 0) begin
      $display("%0d expected results never arrived", expected_replies.size());
      errors++;
    end

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
